>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the modifier chord detector.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the reset is applied.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/mdtc_pkg.sv
// Shared types, constants and key decode functions of the modifier chord detector.
// Stands alone; used by every module of the block.
package mdtc_pkg;

   localparam int KEY_CODES_DEF   = 256;
   localparam int MAX_PENDING_DEF = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_MOD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_MOD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DOUBLE_WIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CHORD_WIN    = 3'd4;

   localparam logic [15:0] DOUBLE_WIN_RESET = 16'd350;
   localparam logic [15:0] CHORD_WIN_RESET  = 16'd100;

   typedef logic [2:0] cls_type;

   localparam cls_type CLS_NONE    = 3'd0;
   localparam cls_type CLS_SHIFT   = 3'd1;
   localparam cls_type CLS_CONTROL = 3'd2;
   localparam cls_type CLS_WIN     = 3'd3;
   localparam cls_type CLS_ALT     = 3'd4;

   typedef struct packed {
      logic [7:0]  key_code;
      logic        key_down;
      logic        end_of_poll;
      logic [31:0] time_ms;
      logic        remote_active;
   } req_type;

   typedef struct packed {
      logic [3:0] hotkeys_fired;
      logic       remote_suppressed;
      logic       interference_seen;
   } rsp_type;

   typedef struct packed {
      logic        hotkey_enable;
      cls_type     first_modifier;
      cls_type     second_modifier;
      logic [15:0] double_window_ms;
      logic [15:0] chord_window_ms;
   } cfg_type;

   // Commands from the sample stage to the walk unit.
   typedef struct packed {
      logic        push;
      logic [3:0]  entry;
      logic        interfere;
      logic        start;
      logic [31:0] now;
      logic        remote;
   } walk_cmd_type;

   typedef struct packed {
      logic       done;
      logic [3:0] fired;
      logic       suppressed;
   } walk_sts_type;

   function automatic cls_type modifier_class(input logic [7:0] code);
      cls_type cls;
      case (code)
         8'hA0, 8'hA1: cls = CLS_SHIFT;
         8'hA2, 8'hA3: cls = CLS_CONTROL;
         8'h5B, 8'h5C: cls = CLS_WIN;
         8'hA4, 8'hA5: cls = CLS_ALT;
         default:      cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   // Keys whose edges count as interference with a modifier gesture.
   function automatic logic is_other_key(input logic [7:0] code);
      logic hit;
      case (code) inside
         8'h08, 8'h09, [8'h20:8'h24], 8'h2D, 8'h2E, [8'h30:8'h39], [8'h41:8'h5A],
         [8'h60:8'h87], [8'hBA:8'hC0], [8'hDB:8'hDF], 8'hE2: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

>>> rtl/mdtc_key_store.sv
// Per-key previous-state memory with a clearing pass after reset.
// Depends on mdtc_pkg for its default depth.
module mdtc_key_store #(
   parameter int DEPTH = mdtc_pkg::KEY_CODES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   output logic          busy
);

   logic          mem [DEPTH];
   logic          rd_data_ff;
   logic          busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> rtl/mdtc_walker.sv
// Edge queue memory and the poll-end walk that checks double taps and chords.
// Depends on mdtc_pkg for the command, status and configuration types.
module mdtc_walker #(
   parameter int MAX_PENDING = mdtc_pkg::MAX_PENDING_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mdtc_pkg::cfg_type      cfg,
   input  mdtc_pkg::walk_cmd_type cmd,
   output mdtc_pkg::walk_sts_type sts
);

   localparam int QAW = $clog2(MAX_PENDING);
   localparam int CW  = $clog2(MAX_PENDING + 1);

   typedef enum logic {
      W_IDLE,
      W_RUN
   } walk_state_type;

   walk_state_type    state_ff;
   logic [3:0]        q_mem [MAX_PENDING];
   logic [3:0]        q_rd_ff;
   logic [QAW-1:0]    q_rd_addr;
   logic              q_wr_en;
   logic [CW-1:0]     count_ff;
   logic [QAW-1:0]    idx_ff;
   mdtc_pkg::cls_type last_mod_ff;
   logic [31:0]       last_time_ff;
   logic              other_ff;
   logic [3:0]        fired_ff;
   logic              supp_ff;
   logic              done_ff;
   logic [31:0]       now_ff;
   logic              remote_ff;

   mdtc_pkg::cls_type e_cls;
   logic              e_down;
   logic [31:0]       dt;
   logic              dbl;
   logic              chord;
   logic              pair;
   logic              last_entry;
   logic              hit;

   assign q_wr_en   = (state_ff == W_IDLE) && cmd.push && (count_ff < CW'(MAX_PENDING));
   // While walking, the next entry is fetched as the current one is evaluated.
   assign q_rd_addr = (state_ff == W_RUN) ? idx_ff + QAW'(1) : '0;

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         q_mem[count_ff[QAW-1:0]] <= cmd.entry;
      end
      q_rd_ff <= q_mem[q_rd_addr];
   end

   always_comb begin
      e_cls      = q_rd_ff[3:1];
      e_down     = q_rd_ff[0];
      dt         = now_ff - last_time_ff;
      dbl        = (last_mod_ff == e_cls) && (dt < 32'(cfg.double_window_ms));
      chord      = (last_mod_ff != e_cls) && (dt < 32'(cfg.chord_window_ms));
      pair       = ((cfg.first_modifier == e_cls) && (cfg.second_modifier == last_mod_ff))
                || ((cfg.first_modifier == last_mod_ff) && (cfg.second_modifier == e_cls));
      last_entry = (CW'(idx_ff) + CW'(1)) == count_ff;
      hit        = !e_down && (dbl || chord) && pair && !other_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         last_mod_ff  <= mdtc_pkg::CLS_NONE;
         last_time_ff <= '0;
         other_ff     <= 1'b0;
         fired_ff     <= '0;
         supp_ff      <= 1'b0;
         done_ff      <= 1'b0;
         now_ff       <= '0;
         remote_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            W_IDLE: begin
               if (cmd.interfere) begin
                  count_ff     <= '0;
                  last_mod_ff  <= mdtc_pkg::CLS_NONE;
                  last_time_ff <= '0;
                  other_ff     <= 1'b1;
               end else if (q_wr_en) begin
                  count_ff <= count_ff + CW'(1);
               end
               if (cmd.start) begin
                  now_ff    <= cmd.now;
                  remote_ff <= cmd.remote;
                  fired_ff  <= '0;
                  supp_ff   <= 1'b0;
                  idx_ff    <= '0;
                  if (!cfg.hotkey_enable || (count_ff == '0)) begin
                     done_ff  <= 1'b1;
                     count_ff <= '0;
                  end else begin
                     state_ff <= W_RUN;
                  end
               end
            end
            W_RUN: begin
               if (e_down) begin
                  if ((e_cls == cfg.first_modifier) || (e_cls == cfg.second_modifier)) begin
                     other_ff <= 1'b0;
                  end
               end else if (dbl || chord) begin
                  if (pair && !other_ff) begin
                     last_mod_ff  <= mdtc_pkg::CLS_NONE;
                     last_time_ff <= '0;
                     if (remote_ff) begin
                        supp_ff <= 1'b1;
                     end else begin
                        fired_ff <= fired_ff + 4'd1;
                     end
                  end
               end else begin
                  last_mod_ff  <= e_cls;
                  last_time_ff <= now_ff;
               end
               idx_ff <= idx_ff + QAW'(1);
               // A suppressed detection ends the walk early.
               if (last_entry || (hit && remote_ff)) begin
                  state_ff <= W_IDLE;
                  done_ff  <= 1'b1;
                  count_ff <= '0;
               end
            end
            default: begin
               state_ff <= W_IDLE;
            end
         endcase
      end
   end

   assign sts.done       = done_ff;
   assign sts.fired      = fired_ff;
   assign sts.suppressed = supp_ff;

endmodule

>>> rtl/modifier_double_tap_chord_detector.sv
// Modifier double-tap and chord detector: after reset the key state memory is cleared
// entry by entry, during which req_ready stays low. A sample transaction has two steps:
// one reads the key's previous state from the key memory and one writes it back and
// queues any modifier edge. A transaction marked end_of_poll then waits in a kick step
// while an earlier result has not been taken, and the walk unit then steps through the
// edge queue memory, one queued edge after another (at most MAX_PENDING). Each poll end
// gives one result transaction; other samples give none. Configuration writes are taken
// in any cycle and belong between polls.
`include "assert_macros.svh"

module modifier_double_tap_chord_detector #(
   parameter int KEY_CODES   = mdtc_pkg::KEY_CODES_DEF,
   parameter int MAX_PENDING = mdtc_pkg::MAX_PENDING_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mdtc_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mdtc_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [mdtc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mdtc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int KAW = $clog2(KEY_CODES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SAMPLE,
      S_KICK,
      S_WALK
   } state_type;

   state_type              state_ff;
   mdtc_pkg::req_type      item_ff;
   mdtc_pkg::cfg_type      cfg_ff;
   logic                   poll_int_ff;
   logic                   rsp_valid_ff;
   mdtc_pkg::rsp_type      rsp_ff;

   logic                   ks_rd_en;
   logic                   ks_rd_data;
   logic                   ks_wr_en;
   logic                   ks_busy;
   mdtc_pkg::cls_type      cls;
   logic                   other;
   logic                   key_edge;
   logic                   in_sample;
   logic                   accept;
   mdtc_pkg::walk_cmd_type walk_cmd;
   mdtc_pkg::walk_sts_type walk_sts;

   assign req_ready = (state_ff == S_IDLE) && !ks_busy;
   assign accept    = req_valid && req_ready;
   assign ks_rd_en  = accept;

   always_comb begin
      cls       = mdtc_pkg::modifier_class(item_ff.key_code);
      other     = mdtc_pkg::is_other_key(item_ff.key_code);
      key_edge  = ks_rd_data != item_ff.key_down;
      in_sample = (state_ff == S_SAMPLE) && cfg_ff.hotkey_enable;
      // Unlisted keys never touch the store; other keys are ignored once a poll is disturbed.
      ks_wr_en  = in_sample && ((cls != mdtc_pkg::CLS_NONE) || (other && !poll_int_ff));

      walk_cmd.push      = in_sample && (cls != mdtc_pkg::CLS_NONE) && key_edge;
      walk_cmd.entry     = {cls, item_ff.key_down};
      walk_cmd.interfere = in_sample && (cls == mdtc_pkg::CLS_NONE) && other
                        && !poll_int_ff && key_edge;
      walk_cmd.start     = (state_ff == S_KICK) && !rsp_valid_ff;
      walk_cmd.now       = item_ff.time_ms;
      walk_cmd.remote    = item_ff.remote_active;
   end

   mdtc_key_store #(
      .DEPTH (KEY_CODES)
   ) u_key_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ks_rd_en),
      .rd_addr (KAW'(req_payload.key_code)),
      .rd_data (ks_rd_data),
      .wr_en   (ks_wr_en),
      .wr_addr (KAW'(item_ff.key_code)),
      .wr_data (item_ff.key_down),
      .busy    (ks_busy)
   );

   mdtc_walker #(
      .MAX_PENDING (MAX_PENDING)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .cmd   (walk_cmd),
      .sts   (walk_sts)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         poll_int_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
         cfg_ff.hotkey_enable    <= 1'b0;
         cfg_ff.first_modifier   <= mdtc_pkg::CLS_NONE;
         cfg_ff.second_modifier  <= mdtc_pkg::CLS_NONE;
         cfg_ff.double_window_ms <= mdtc_pkg::DOUBLE_WIN_RESET;
         cfg_ff.chord_window_ms  <= mdtc_pkg::CHORD_WIN_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mdtc_pkg::REG_ENABLE:     cfg_ff.hotkey_enable    <= csr_wdata[0];
               mdtc_pkg::REG_FIRST_MOD:  cfg_ff.first_modifier   <= csr_wdata[2:0];
               mdtc_pkg::REG_SECOND_MOD: cfg_ff.second_modifier  <= csr_wdata[2:0];
               mdtc_pkg::REG_DOUBLE_WIN: cfg_ff.double_window_ms <= csr_wdata;
               mdtc_pkg::REG_CHORD_WIN:  cfg_ff.chord_window_ms  <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SAMPLE;
               end
            end
            S_SAMPLE: begin
               if (walk_cmd.interfere) begin
                  poll_int_ff <= 1'b1;
               end
               state_ff <= item_ff.end_of_poll ? S_KICK : S_IDLE;
            end
            S_KICK: begin
               // The walk starts only once the result register is free.
               if (walk_cmd.start) begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (walk_sts.done) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_ff.hotkeys_fired        <= walk_sts.fired;
                  rsp_ff.remote_suppressed    <= walk_sts.suppressed;
                  rsp_ff.interference_seen    <= cfg_ff.hotkey_enable && poll_int_ff;
                  poll_int_ff                 <= 1'b0;
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_RST(a_result_from_walk, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_WALK))
   `ASSERT_RST(a_start_with_free_output, clock, reset, walk_cmd.start |-> !rsp_valid_ff && !walk_sts.done)
   `ASSERT_RST(a_fired_bounded, clock, reset, rsp_valid_ff |-> rsp_ff.hotkeys_fired <= 4'(MAX_PENDING))
   `ASSERT_ALWAYS(a_no_accept_while_clearing, clock, ks_busy |-> !accept)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the modifier double-tap and chord detector.
// Needs mdtc_pkg and the detector RTL only; stimulus, prediction and checking live here.
module tb_top;

   localparam logic [7:0] KEY_LSHIFT = 8'hA0;
   localparam logic [7:0] KEY_RSHIFT = 8'hA1;
   localparam logic [7:0] KEY_LCTRL  = 8'hA2;
   localparam logic [7:0] KEY_RCTRL  = 8'hA3;
   localparam logic [7:0] KEY_LWIN   = 8'h5B;
   localparam logic [7:0] KEY_RWIN   = 8'h5C;
   localparam logic [7:0] KEY_LALT   = 8'hA4;
   localparam logic [7:0] KEY_RALT   = 8'hA5;
   localparam logic [7:0] KEY_A      = 8'h41;
   localparam mdtc_pkg::cls_type CLS_UNUSED = 3'd7;

   localparam int NUM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE  = 165;
   localparam int SETTLE_CYCLES    = 20;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_ready;
   mdtc_pkg::req_type                req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_ready   = 1'b0;
   mdtc_pkg::rsp_type                rsp_payload;
   logic                             csr_wr_en   = 1'b0;
   logic [mdtc_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [mdtc_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   modifier_double_tap_chord_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Detector state as the testbench expects it to be.
   mdtc_pkg::cfg_type hk_cfg = '{1'b0, mdtc_pkg::CLS_NONE, mdtc_pkg::CLS_NONE,
                                 mdtc_pkg::DOUBLE_WIN_RESET, mdtc_pkg::CHORD_WIN_RESET};
   bit                key_held [mdtc_pkg::KEY_CODES_DEF];
   mdtc_pkg::cls_type last_mod        = mdtc_pkg::CLS_NONE;
   logic [31:0]       last_release_ms = '0;
   bit                other_seen      = 1'b0;
   logic [3:0]        queued_edges [mdtc_pkg::MAX_PENDING_DEF];
   int                queued_count    = 0;
   bit                poll_disturbed  = 1'b0;

   mdtc_pkg::rsp_type expected_results [$];
   mdtc_pkg::req_type sample_q [$];
   int                mismatches = 0;

   logic [7:0]  mod_keys [0:7] = '{KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL, KEY_RCTRL,
                                   KEY_LWIN, KEY_RWIN, KEY_LALT, KEY_RALT};
   logic [31:0] poll_ms      = 32'd1000;
   int          phase_items  = 0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          long_hold    = 1'b0;
   int          send_gap     = 0;
   int          recv_gap     = 0;
   int          hold_left    = 0;
   logic        req_fired    = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic mdtc_pkg::cls_type mod_group(input logic [7:0] code);
      case (code)
         KEY_LSHIFT, KEY_RSHIFT: return mdtc_pkg::CLS_SHIFT;
         KEY_LCTRL, KEY_RCTRL:   return mdtc_pkg::CLS_CONTROL;
         KEY_LWIN, KEY_RWIN:     return mdtc_pkg::CLS_WIN;
         KEY_LALT, KEY_RALT:     return mdtc_pkg::CLS_ALT;
         default:                return mdtc_pkg::CLS_NONE;
      endcase
   endfunction

   function automatic bit other_key_code(input logic [7:0] code);
      return code == 8'h08 || code == 8'h09 || (code >= 8'h20 && code <= 8'h24) ||
             code == 8'h2D || code == 8'h2E || (code >= 8'h30 && code <= 8'h39) ||
             (code >= 8'h41 && code <= 8'h5A) || (code >= 8'h60 && code <= 8'h87) ||
             (code >= 8'hBA && code <= 8'hC0) || (code >= 8'hDB && code <= 8'hDF) ||
             code == 8'hE2;
   endfunction

   task automatic take_sample(input logic [7:0] code, input logic down);
      mdtc_pkg::cls_type cls;
      bit                changed;
      cls = mod_group(code);
      if (cls != mdtc_pkg::CLS_NONE) begin
         changed = key_held[code] != down;
         key_held[code] = down;
         if (changed && queued_count < mdtc_pkg::MAX_PENDING_DEF) begin
            queued_edges[queued_count] = {cls, down};
            queued_count++;
         end
      end else if (other_key_code(code) && !poll_disturbed) begin
         changed = key_held[code] != down;
         key_held[code] = down;
         // The first other-key change of a poll spoils any gesture in progress.
         if (changed) begin
            queued_count    = 0;
            other_seen      = 1'b1;
            last_mod        = mdtc_pkg::CLS_NONE;
            last_release_ms = '0;
            poll_disturbed  = 1'b1;
         end
      end
   endtask

   task automatic walk_edges(input logic [31:0] now_ms, input logic remote,
                             output logic [3:0] fired, output logic suppressed);
      mdtc_pkg::cls_type cls;
      mdtc_pkg::cls_type prev_cls;
      logic              down;
      logic [31:0]       elapsed;
      bit                dbl, chord, fwd, rev, stop;
      fired      = '0;
      suppressed = 1'b0;
      stop       = 1'b0;
      for (int i = 0; i < queued_count && !stop; i++) begin
         cls      = queued_edges[i][3:1];
         down     = queued_edges[i][0];
         prev_cls = last_mod;
         elapsed  = now_ms - last_release_ms;
         dbl      = prev_cls == cls && elapsed < {16'd0, hk_cfg.double_window_ms};
         chord    = prev_cls != cls && elapsed < {16'd0, hk_cfg.chord_window_ms};
         fwd      = hk_cfg.first_modifier == cls && hk_cfg.second_modifier == prev_cls;
         rev      = hk_cfg.first_modifier == prev_cls && hk_cfg.second_modifier == cls;
         if (down) begin
            // Pressing one of the configured modifiers forgives earlier interference.
            if (cls == hk_cfg.first_modifier || cls == hk_cfg.second_modifier)
               other_seen = 1'b0;
         end else if (dbl || chord) begin
            if ((fwd || rev) && !other_seen) begin
               last_mod        = mdtc_pkg::CLS_NONE;
               last_release_ms = '0;
               if (remote) begin
                  suppressed = 1'b1;
                  stop       = 1'b1;
               end else begin
                  fired = fired + 4'd1;
               end
            end
         end else begin
            last_mod        = cls;
            last_release_ms = now_ms;
         end
      end
   endtask

   task automatic predict_result(input mdtc_pkg::req_type item);
      mdtc_pkg::rsp_type res;
      logic [3:0]        fired;
      logic              suppressed;
      res = '0;
      if (hk_cfg.hotkey_enable)
         take_sample(item.key_code, item.key_down);
      if (item.end_of_poll) begin
         if (hk_cfg.hotkey_enable) begin
            walk_edges(item.time_ms, item.remote_active, fired, suppressed);
            res.hotkeys_fired     = fired;
            res.remote_suppressed = suppressed;
            res.interference_seen = poll_disturbed;
         end
         queued_count   = 0;
         poll_disturbed = 1'b0;
         expected_results.insert(expected_results.size(), res);
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("tb_top: mismatch at %0t ns: %s", $time, msg);
   endtask

   // Sender: a new transaction is offered only once the previous one has been taken.
   always @(negedge clock) begin : drive_req
      logic offer;
      offer = req_valid && !req_fired;
      if (reset) begin
         offer = 1'b0;
      end else if (!offer) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 9);
         end else if (sample_q.size() > 0) begin
            req_payload <= sample_q.pop_front();
            offer = 1'b1;
         end
      end
      req_valid <= offer;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin : drive_rsp_ready
      logic rdy;
      rdy = 1'b1;
      if (long_hold) begin
         long_hold = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rdy = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
         recv_gap = $urandom_range(0, 9);
         rdy = 1'b0;
      end
      rsp_ready <= rdy && !reset;
   end

   always @(posedge clock) begin : check_results
      mdtc_pkg::rsp_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result fired %0d suppressed %0d inter %0d",
                  rsp_payload.hotkeys_fired, rsp_payload.remote_suppressed,
                  rsp_payload.interference_seen));
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.hotkeys_fired !== want.hotkeys_fired ||
                   rsp_payload.remote_suppressed !== want.remote_suppressed ||
                   rsp_payload.interference_seen !== want.interference_seen)
                  report_mismatch($sformatf(
                     "fired %0d/%0d suppressed %0d/%0d interference %0d/%0d (got/expected)",
                     rsp_payload.hotkeys_fired, want.hotkeys_fired,
                     rsp_payload.remote_suppressed, want.remote_suppressed,
                     rsp_payload.interference_seen, want.interference_seen));
            end
         end
         if (req_valid && req_ready)
            predict_result(req_payload);
      end
   end

   task automatic cfg_write(input logic [mdtc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         mdtc_pkg::REG_ENABLE:     hk_cfg.hotkey_enable    = val[0];
         mdtc_pkg::REG_FIRST_MOD:  hk_cfg.first_modifier   = val[2:0];
         mdtc_pkg::REG_SECOND_MOD: hk_cfg.second_modifier  = val[2:0];
         mdtc_pkg::REG_DOUBLE_WIN: hk_cfg.double_window_ms = val;
         mdtc_pkg::REG_CHORD_WIN:  hk_cfg.chord_window_ms  = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic en, input mdtc_pkg::cls_type first,
                             input mdtc_pkg::cls_type second,
                             input logic [15:0] dbl_win, input logic [15:0] chord_win);
      cfg_write(mdtc_pkg::REG_ENABLE, {15'd0, en});
      cfg_write(mdtc_pkg::REG_FIRST_MOD, {13'd0, first});
      cfg_write(mdtc_pkg::REG_SECOND_MOD, {13'd0, second});
      cfg_write(mdtc_pkg::REG_DOUBLE_WIN, dbl_win);
      cfg_write(mdtc_pkg::REG_CHORD_WIN, chord_win);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_sample(input logic [7:0] code, input logic down);
      mdtc_pkg::req_type it;
      it.key_code      = code;
      it.key_down      = down;
      it.end_of_poll   = 1'b0;
      it.time_ms       = $urandom;
      it.remote_active = 1'($urandom_range(0, 1));
      sample_q.insert(sample_q.size(), it);
      phase_items++;
   endtask

   task automatic add_poll_end(input logic [7:0] code, input logic down, input logic remote);
      mdtc_pkg::req_type it;
      it.key_code      = code;
      it.key_down      = down;
      it.end_of_poll   = 1'b1;
      it.time_ms       = poll_ms;
      it.remote_active = remote;
      sample_q.insert(sample_q.size(), it);
      phase_items++;
   endtask

   function automatic logic [7:0] random_key();
      logic [7:0] code;
      case ($urandom_range(0, 3))
         0, 1: code = mod_keys[$urandom_range(0, 7)];
         2: begin
            code = 8'($urandom_range(0, 255));
            while (!other_key_code(code))
               code = 8'($urandom_range(0, 255));
         end
         default: code = 8'($urandom_range(0, 255));
      endcase
      return code;
   endfunction

   function automatic mdtc_pkg::cls_type random_class();
      if ($urandom_range(0, 9) < 8)
         return mdtc_pkg::cls_type'($urandom_range(0, 4));
      return mdtc_pkg::cls_type'($urandom_range(5, 7));
   endfunction

   function automatic logic [15:0] random_window();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 120));
         default: return 16'($urandom_range(0, 1000));
      endcase
   endfunction

   // Mostly modifier taps with random keys, timing and stray samples; the rest is noise.
   task automatic add_random_poll();
      int         taps;
      int         n;
      bit         closed;
      bit         remote;
      logic [7:0] code;
      case ($urandom_range(0, 19))
         0:          poll_ms = $urandom;
         1, 2, 3:    poll_ms = poll_ms + $urandom_range(0, 20);
         4, 5, 6, 7, 8, 9, 10, 11: poll_ms = poll_ms + 32'd50;
         default:    poll_ms = poll_ms + $urandom_range(60, 600);
      endcase
      remote = $urandom_range(0, 3) == 0;
      closed = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
         taps = $urandom_range(1, 3);
         for (int k = 0; k < taps; k++) begin
            code = mod_keys[$urandom_range(0, 7)];
            add_sample(code, 1'b1);
            if ($urandom_range(0, 6) == 0)
               add_sample(random_key(), 1'($urandom_range(0, 1)));
            if (k == taps - 1 && $urandom_range(0, 1) == 1) begin
               add_poll_end(code, 1'b0, remote);
               closed = 1'b1;
            end else begin
               add_sample(code, 1'b0);
            end
         end
         if (!closed)
            add_poll_end(random_key(), 1'($urandom_range(0, 1)), remote);
      end else begin
         n = $urandom_range(0, 11);
         for (int k = 0; k < n; k++)
            add_sample(random_key(), 1'($urandom_range(0, 1)));
         add_poll_end(random_key(), 1'($urandom_range(0, 1)), remote);
      end
   endtask

   // Returns once every transaction has been taken and every result has come back.
   task automatic wait_drained();
      while (sample_q.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Detection is off after reset: the poll still ends with an all-zero result.
      add_sample(KEY_LSHIFT, 1'b1);
      add_poll_end(KEY_LSHIFT, 1'b0, 1'b0);
      wait_drained();

      set_config(1'b1, mdtc_pkg::CLS_SHIFT, mdtc_pkg::CLS_CONTROL,
                 mdtc_pkg::DOUBLE_WIN_RESET, mdtc_pkg::CHORD_WIN_RESET);
      // Shift then control within one poll; the marked transaction carries the last release.
      poll_ms = 32'd1000;
      add_sample(KEY_LSHIFT, 1'b1);
      add_sample(KEY_LSHIFT, 1'b0);
      add_sample(KEY_LCTRL, 1'b1);
      add_poll_end(KEY_LCTRL, 1'b0, 1'b0);
      // An unlisted key at the top of the code range.
      poll_ms = 32'd1040;
      add_poll_end(8'hFF, 1'b1, 1'b0);
      // An other key pressed mid-gesture; modifier edges after it are still queued.
      poll_ms = 32'd1100;
      add_sample(KEY_A, 1'b1);
      add_sample(KEY_LSHIFT, 1'b1);
      add_sample(KEY_LSHIFT, 1'b0);
      add_poll_end(8'h00, 1'b0, 1'b1);
      // Ten modifier edges in one poll overflow the eight-entry queue.
      poll_ms = 32'd1150;
      add_sample(KEY_A, 1'b0);
      add_sample(KEY_LWIN, 1'b1);
      add_sample(KEY_LWIN, 1'b0);
      add_sample(KEY_RWIN, 1'b1);
      add_sample(KEY_RWIN, 1'b0);
      add_sample(KEY_LALT, 1'b1);
      add_sample(KEY_LALT, 1'b0);
      add_sample(KEY_RALT, 1'b1);
      add_sample(KEY_RALT, 1'b0);
      add_sample(KEY_RCTRL, 1'b1);
      add_poll_end(KEY_RCTRL, 1'b0, 1'b0);
      // A chord across the time wrap, detected while the remote session is in front.
      poll_ms = 32'hFFFF_FFF0;
      add_sample(KEY_RSHIFT, 1'b1);
      add_poll_end(KEY_RSHIFT, 1'b0, 1'b0);
      poll_ms = 32'h0000_0020;
      add_sample(KEY_LCTRL, 1'b1);
      add_poll_end(KEY_LCTRL, 1'b0, 1'b1);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_on = ph != NUM_PHASES - 1 && $urandom_range(0, 3) != 0;
         recv_idle_on = ph != NUM_PHASES - 1 && $urandom_range(0, 3) != 0;
         case (ph)
            0: set_config(1'b1, mdtc_pkg::CLS_SHIFT, mdtc_pkg::CLS_SHIFT, 16'hFFFF, 16'hFFFF);
            1: set_config(1'b1, random_class(), random_class(), 16'd0, 16'd0);
            2: set_config(1'b0, mdtc_pkg::CLS_ALT, mdtc_pkg::CLS_WIN, random_window(),
                          random_window());
            3: begin
               set_config(1'b1, mdtc_pkg::CLS_WIN, mdtc_pkg::CLS_ALT,
                          mdtc_pkg::DOUBLE_WIN_RESET, mdtc_pkg::CHORD_WIN_RESET);
               // Results back up while the sender keeps going, so the input stalls.
               long_hold = 1'b1;
            end
            4: set_config(1'b1, CLS_UNUSED, random_class(), random_window(), random_window());
            5: set_config(1'b1, mdtc_pkg::CLS_NONE, random_class(), random_window(),
                          random_window());
            default: set_config(1'b1, random_class(), random_class(), random_window(),
                                random_window());
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE)
            add_random_poll();
         wait_drained();
      end

      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/mdtc_pkg.sv
rtl/mdtc_key_store.sv
rtl/mdtc_walker.sv
rtl/modifier_double_tap_chord_detector.sv
sim/tb_top.sv
